>>> rtl/clre_pkg.sv
// package for the character lcd refresh engine
// widths, function codes, register indexes and divider constants
// no dependencies
package clre_pkg;

    // payload widths
    localparam int FUNC_W    = 3;
    localparam int ROW_W     = 3;
    localparam int COL_W     = 4;
    localparam int BYTE_W    = 8;
    localparam int NUM_W     = 16;
    localparam int CFG_IDX_W = 2;

    // default buffer geometry
    localparam int ROWS_DEF    = 8;
    localparam int COLUMNS_DEF = 16;

    // buffer split into column banks so four digits land in four banks
    localparam int BANK_W = 2;
    localparam int BANKS  = 1 << BANK_W;
    localparam int DIGITS = 4;

    localparam int DISP_LAST_COL = 15;
    localparam int ASCII_ZERO    = 48;
    localparam int DEC_BASE      = 10;

    // reciprocal multipliers, exact for any 16-bit dividend
    localparam int RECIP_W       = 17;
    localparam int PROD_W        = NUM_W + RECIP_W;
    localparam int RECIP_10      = 52429;
    localparam int SHIFT_10      = 19;
    localparam int RECIP_100     = 83887;
    localparam int SHIFT_100     = 23;
    localparam int RECIP_1000    = 67109;
    localparam int SHIFT_1000    = 26;
    localparam int RECIP_10000   = 107375;
    localparam int SHIFT_10000   = 30;

    // quotient widths: 65535 / 10, / 100, / 1000, / 10000
    localparam int Q10_W    = 13;
    localparam int Q100_W   = 10;
    localparam int Q1000_W  = 7;
    localparam int Q10000_W = 3;

    typedef enum logic [FUNC_W-1:0] {
        FN_TICK   = 3'd0,
        FN_CHAR   = 3'd1,
        FN_UP     = 3'd2,
        FN_DOWN   = 3'd3,
        FN_NUMBER = 3'd4
    } func_t;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_ONE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_TWO = 2'd1;

    localparam logic [BYTE_W-1:0] LINE_ONE_RESET = 8'd128;
    localparam logic [BYTE_W-1:0] LINE_TWO_RESET = 8'd192;

    // ascii bytes of a four-digit number, index 0 is the thousands digit
    typedef logic [DIGITS-1:0][BYTE_W-1:0] digits_t;

endpackage

>>> rtl/clre_ram.sv
// generic single-write, single-read ram with registered read data
// no package dependencies
module clre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/clre_digits.sv
// decimal split of a 16-bit number into four ascii digits
// one register stage of reciprocal quotients; depends on clre_pkg
module clre_digits (
    input  logic                         clk,
    input  logic                         en,
    input  logic [clre_pkg::NUM_W-1:0]   number,
    output clre_pkg::digits_t            digits
);

    import clre_pkg::*;

    logic [PROD_W-1:0]   p10;
    logic [PROD_W-1:0]   p100;
    logic [PROD_W-1:0]   p1000;
    logic [PROD_W-1:0]   p10000;
    logic [NUM_W-1:0]    num_reg;
    logic [Q10_W-1:0]    q10_reg;
    logic [Q100_W-1:0]   q100_reg;
    logic [Q1000_W-1:0]  q1000_reg;
    logic [Q10000_W-1:0] q10000_reg;
    logic [NUM_W-1:0]    rem_units;
    logic [NUM_W-1:0]    rem_tens;
    logic [NUM_W-1:0]    rem_hundreds;
    logic [NUM_W-1:0]    rem_thousands;

    // four independent constant multiplies
    always_comb
    begin
        p10    = PROD_W'(number) * PROD_W'(RECIP_10);
        p100   = PROD_W'(number) * PROD_W'(RECIP_100);
        p1000  = PROD_W'(number) * PROD_W'(RECIP_1000);
        p10000 = PROD_W'(number) * PROD_W'(RECIP_10000);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg    <= number;
            q10_reg    <= Q10_W'(p10 >> SHIFT_10);
            q100_reg   <= Q100_W'(p100 >> SHIFT_100);
            q1000_reg  <= Q1000_W'(p1000 >> SHIFT_1000);
            q10000_reg <= Q10000_W'(p10000 >> SHIFT_10000);
        end
    end

    // each digit is a quotient less ten times the next coarser one
    always_comb
    begin
        rem_units     = num_reg - NUM_W'(q10_reg) * NUM_W'(DEC_BASE);
        rem_tens      = NUM_W'(q10_reg) - NUM_W'(q100_reg) * NUM_W'(DEC_BASE);
        rem_hundreds  = NUM_W'(q100_reg) - NUM_W'(q1000_reg) * NUM_W'(DEC_BASE);
        rem_thousands = NUM_W'(q1000_reg) - NUM_W'(q10000_reg) * NUM_W'(DEC_BASE);
        digits[0] = BYTE_W'(ASCII_ZERO) + BYTE_W'(rem_thousands[3:0]);
        digits[1] = BYTE_W'(ASCII_ZERO) + BYTE_W'(rem_hundreds[3:0]);
        digits[2] = BYTE_W'(ASCII_ZERO) + BYTE_W'(rem_tens[3:0]);
        digits[3] = BYTE_W'(ASCII_ZERO) + BYTE_W'(rem_units[3:0]);
    end

endmodule

>>> rtl/char_lcd_refresh_engine.sv
// top level of the character lcd refresh engine
// buffer banks, refresh sequencer, scroll pointer and output stage
// depends on clre_pkg, clre_ram and clre_digits
//
// usage
//  input channel (in_valid / in_stall) carries one item per transaction:
//  a refresh tick, a character write, a number write or a scroll move
//  only a refresh tick gives an output transaction (is_data, bus_byte),
//  one lcd bus write: a line select command or one data byte
//  configuration channel (cfg_valid / cfg_ready, always ready) sets the
//  two line select command bytes; write it only while the block is idle
//  throughput: one item per clock, set by the single access per item to
//  the four column banks of the buffer
//  latency: a tick's result is shown three cycles after its accepting edge
//  (input register, digit / address stage, bank read, output register)
//  reset: the buffer is cleared by a pass of ROWS * ceil(COLUMNS / 4)
//  cycles (32 at the default size) while in_stall is held high; the
//  configuration channel is served during the pass
//  when the receiver stalls, the whole pipeline holds and in_stall rises
//  in the same cycle; the pending result stays on the port unchanged
module char_lcd_refresh_engine #(
    parameter int ROWS    = clre_pkg::ROWS_DEF,
    parameter int COLUMNS = clre_pkg::COLUMNS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [clre_pkg::FUNC_W-1:0]      func,
    input  logic [clre_pkg::ROW_W-1:0]       row,
    input  logic [clre_pkg::COL_W-1:0]       col,
    input  logic [clre_pkg::BYTE_W-1:0]      char_code,
    input  logic [clre_pkg::NUM_W-1:0]       number,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             is_data,
    output logic [clre_pkg::BYTE_W-1:0]      bus_byte,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [clre_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [clre_pkg::BYTE_W-1:0]      cfg_data
);

    import clre_pkg::*;

    // words per buffer row in each bank, and bank geometry
    localparam int WPR   = (COLUMNS + BANKS - 1) / BANKS;
    localparam int DEPTH = ROWS * WPR;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(ROWS);

    typedef enum logic [1:0] {
        PH_SEL1,
        PH_WR1,
        PH_SEL2,
        PH_WR2
    } phase_t;

    // pipeline control
    logic                adv;
    logic                accept;
    logic                clearing_reg;
    logic [AW-1:0]       clr_addr_reg;

    // input register stage
    logic                a_valid_reg;
    logic [FUNC_W-1:0]   a_func_reg;
    logic [ROW_W-1:0]    a_row_reg;
    logic [COL_W-1:0]    a_col_reg;
    logic [BYTE_W-1:0]   a_char_reg;
    logic [NUM_W-1:0]    a_number_reg;

    // digit / address stage
    logic                b_valid_reg;
    logic [FUNC_W-1:0]   b_func_reg;
    logic [ROW_W-1:0]    b_row_reg;
    logic [COL_W-1:0]    b_col_reg;
    logic [BYTE_W-1:0]   b_char_reg;
    digits_t             digits;
    logic                b_row_ok;

    // configuration registers
    logic [BYTE_W-1:0]   line_one_reg;
    logic [BYTE_W-1:0]   line_two_reg;

    // refresh sequencer and scroll pointer
    phase_t              phase_reg;
    phase_t              phase_next;
    logic [COL_W-1:0]    col_cnt_reg;
    logic [COL_W-1:0]    col_cnt_next;
    logic [RW-1:0]       scroll_reg;
    logic [RW-1:0]       scroll_next;

    logic                fire;
    logic                tick_fire;
    logic                is_cmd;
    logic [RW-1:0]       rd_row;
    logic                rd_col_ok;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;

    // bank read stage and output register
    logic                r_valid_reg;
    logic                r_is_data_reg;
    logic                r_zero_reg;
    logic [BYTE_W-1:0]   r_cmd_reg;
    logic [BANK_W-1:0]   r_bank_reg;
    logic [BYTE_W-1:0]   bank_rdata [BANKS];
    logic [BYTE_W-1:0]   out_byte;
    logic                out_valid_reg;
    logic                is_data_reg;
    logic [BYTE_W-1:0]   bus_byte_reg;

    // whole pipeline moves unless a shown result is being held
    assign adv       = !out_valid_reg || !out_stall;
    assign in_stall  = clearing_reg || !adv;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign out_valid = out_valid_reg;
    assign is_data   = is_data_reg;
    assign bus_byte  = bus_byte_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_one_reg <= LINE_ONE_RESET;
            line_two_reg <= LINE_TWO_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_LINE_ONE: line_one_reg <= cfg_data;
                CFG_LINE_TWO: line_two_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_func_reg   <= func;
            a_row_reg    <= row;
            a_col_reg    <= col;
            a_char_reg   <= char_code;
            a_number_reg <= number;
            b_func_reg   <= a_func_reg;
            b_row_reg    <= a_row_reg;
            b_col_reg    <= a_col_reg;
            b_char_reg   <= a_char_reg;
        end
    end

    // digit quotients are registered alongside the b stage
    clre_digits u_digits (
        .clk    (clk),
        .en     (adv),
        .number (a_number_reg),
        .digits (digits)
    );

    assign fire      = adv && b_valid_reg;
    assign tick_fire = fire && (b_func_reg == FN_TICK);
    assign is_cmd    = (phase_reg == PH_SEL1) || (phase_reg == PH_SEL2);
    assign b_row_ok  = int'(b_row_reg) < ROWS;

    // refresh read: row 0 on line one, row after the scroll pointer on line two
    always_comb
    begin
        rd_row    = (phase_reg == PH_WR1) ? '0 : scroll_reg + RW'(1);
        rd_col_ok = int'(col_cnt_reg) < COLUMNS;
        rd_en     = tick_fire && !is_cmd && rd_col_ok;
        rd_addr   = AW'(int'(rd_row) * WPR + int'(col_cnt_reg >> BANK_W));
    end

    // sequencer and scroll next state
    always_comb
    begin
        phase_next   = phase_reg;
        col_cnt_next = col_cnt_reg;
        scroll_next  = scroll_reg;
        if (fire)
        begin
            case (b_func_reg)
                FN_TICK:
                begin
                    unique case (phase_reg) inside
                        PH_SEL1: phase_next = PH_WR1;
                        PH_SEL2: phase_next = PH_WR2;
                        PH_WR1, PH_WR2:
                        begin
                            if (col_cnt_reg >= COL_W'(DISP_LAST_COL))
                            begin
                                col_cnt_next = '0;
                                phase_next   = (phase_reg == PH_WR1) ? PH_SEL2 : PH_SEL1;
                            end
                            else
                            begin
                                col_cnt_next = col_cnt_reg + COL_W'(1);
                            end
                        end
                        default: phase_next = PH_SEL1;
                    endcase
                end
                FN_UP:
                begin
                    // wraps from the top row to the last scroll position
                    if (scroll_reg == '0)
                    begin
                        scroll_next = RW'(ROWS - 2);
                    end
                    else
                    begin
                        scroll_next = scroll_reg - RW'(1);
                    end
                end
                FN_DOWN:
                begin
                    if (int'(scroll_reg) < ROWS - 2)
                    begin
                        scroll_next = scroll_reg + RW'(1);
                    end
                    else
                    begin
                        scroll_next = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // state, valid bits and the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SEL1;
            col_cnt_reg   <= '0;
            scroll_reg    <= '0;
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            r_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            col_cnt_reg <= col_cnt_next;
            scroll_reg  <= scroll_next;
            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (adv)
            begin
                a_valid_reg   <= accept;
                b_valid_reg   <= a_valid_reg;
                r_valid_reg   <= tick_fire;
                out_valid_reg <= r_valid_reg;
            end
        end
    end

    // column banks: bank b holds columns whose low two bits equal b, so the
    // four digits of a number each go to a bank of their own
    for (genvar b = 0; b < BANKS; b++)
    begin : g_bank
        logic [BANK_W-1:0] k;
        logic [COL_W:0]    wcol;
        logic              wcol_ok;
        logic              we;
        logic [AW-1:0]     waddr;
        logic [BYTE_W-1:0] wdata;
        logic              ram_we;
        logic [AW-1:0]     ram_waddr;
        logic [BYTE_W-1:0] ram_wdata;

        always_comb
        begin
            // offset from the start column that lands in this bank
            k       = BANK_W'(b) - b_col_reg[BANK_W-1:0];
            wcol    = (COL_W + 1)'(b_col_reg) + (COL_W + 1)'(k);
            // writes past the display or the buffer width are dropped
            wcol_ok = (wcol <= (COL_W + 1)'(DISP_LAST_COL)) && (int'(wcol) < COLUMNS)
                      && b_row_ok;
            case (b_func_reg)
                FN_CHAR:   we = fire && (k == '0) && wcol_ok;
                FN_NUMBER: we = fire && wcol_ok;
                default:   we = 1'b0;
            endcase
            wdata     = (b_func_reg == FN_CHAR) ? b_char_reg : digits[k];
            waddr     = AW'(int'(b_row_reg) * WPR + int'(wcol >> BANK_W));
            ram_we    = clearing_reg || we;
            ram_waddr = clearing_reg ? clr_addr_reg : waddr;
            ram_wdata = clearing_reg ? '0 : wdata;
        end

        clre_ram #(
            .WIDTH (BYTE_W),
            .DEPTH (DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (ram_we),
            .waddr (ram_waddr),
            .wdata (ram_wdata),
            .re    (rd_en),
            .raddr (rd_addr),
            .rdata (bank_rdata[b])
        );
    end

    // bank read stage and output register payload
    assign out_byte = !r_is_data_reg ? r_cmd_reg
                    : (r_zero_reg ? '0 : bank_rdata[r_bank_reg]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_is_data_reg <= !is_cmd;
            r_zero_reg    <= !rd_col_ok;
            r_cmd_reg     <= (phase_reg == PH_SEL2) ? line_two_reg : line_one_reg;
            r_bank_reg    <= col_cnt_reg[BANK_W-1:0];
            is_data_reg   <= r_is_data_reg;
            bus_byte_reg  <= out_byte;
        end
    end

    // no item may enter during the clearing pass
    assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> in_stall)
        else $error("item accepted during buffer clear");

    // scroll pointer stays within its wrap range
    assert property (@(posedge clk) disable iff (!rst_n)
        int'(scroll_reg) <= ROWS - 2)
        else $error("scroll pointer out of range");

    // column counter rests at zero in the line select phases
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SEL1 || phase_reg == PH_SEL2) |-> (col_cnt_reg == '0))
        else $error("column counter not zero in select phase");

    // a tick in a select phase becomes a command result in the next stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (tick_fire && is_cmd) |=> (r_valid_reg && !r_is_data_reg))
        else $error("select tick lost or flagged as data");

endmodule

>>> bench/tb.sv
// testbench for the character lcd refresh engine: items, register writes and bus write checks
// keeps a shadow copy of buffer, sequencer and scroll pointer to predict every bus write
// depends on clre_pkg and char_lcd_refresh_engine
module tb;
    import clre_pkg::*;

    localparam int N_ROWS      = ROWS_DEF;
    localparam int N_COLS      = COLUMNS_DEF;
    localparam int LAST_SCROLL = N_ROWS - 2;
    localparam int IDLE_PCT    = 27;
    // lets the pipeline empty, plus margin
    localparam int DRAIN_WAIT  = 8;
    localparam int CYCLE_LIMIT = 200000;

    // func codes the block ignores
    localparam logic [FUNC_W-1:0] FN_UNUSED_A = 3'd5;
    localparam logic [FUNC_W-1:0] FN_UNUSED_B = 3'd6;
    localparam logic [FUNC_W-1:0] FN_UNUSED_C = 3'd7;

    // register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef enum logic [1:0] {
        PH_SEL_ONE,
        PH_WR_ONE,
        PH_SEL_TWO,
        PH_WR_TWO
    } refresh_phase_t;

    typedef struct packed {
        logic              is_data;
        logic [BYTE_W-1:0] bus_byte;
    } bus_write_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic [FUNC_W-1:0]    func      = '0;
    logic [ROW_W-1:0]     row       = '0;
    logic [COL_W-1:0]     col       = '0;
    logic [BYTE_W-1:0]    char_code = '0;
    logic [NUM_W-1:0]     number    = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 is_data;
    logic [BYTE_W-1:0]    bus_byte;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [BYTE_W-1:0]    cfg_data  = '0;

    // set while neither side may idle
    bit calm = 1'b0;
    int fail_count  = 0;
    int cycle_count = 0;

    // shadow state of the block
    logic [BYTE_W-1:0] shadow_buf [N_ROWS][N_COLS];
    refresh_phase_t    shadow_phase;
    int                shadow_col;
    int                shadow_scroll;
    logic [BYTE_W-1:0] shadow_line_one;
    logic [BYTE_W-1:0] shadow_line_two;

    // bus writes predicted but not yet seen, oldest first
    bus_write_t bus_writes_due[$];

    char_lcd_refresh_engine #(
        .ROWS    (N_ROWS),
        .COLUMNS (N_COLS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .row       (row),
        .col       (col),
        .char_code (char_code),
        .number    (number),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .is_data   (is_data),
        .bus_byte  (bus_byte),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // reset held low from the start, released on a falling edge, never asserted again
    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // receiver side: random stall, changed on the falling edge only
    always @(negedge clk)
        out_stall <= rst_n && !calm && ($urandom_range(0, 99) < IDLE_PCT);

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("tb: errors");
            $finish;
        end
    end

    // every output transaction is compared with the oldest due bus write
    always @(posedge clk)
    begin : bus_check
        bus_write_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (bus_writes_due.size() == 0)
            begin
                $display("%0t: bus write with none due, got is_data %0b bus_byte %0h",
                         $time, is_data, bus_byte);
                fail_count++;
            end
            else
            begin
                want = bus_writes_due.pop_front();
                if (is_data !== want.is_data)
                begin
                    $display("%0t: is_data expected %0b got %0b",
                             $time, want.is_data, is_data);
                    fail_count++;
                end
                if (bus_byte !== want.bus_byte)
                begin
                    $display("%0t: bus_byte expected %0h got %0h",
                             $time, want.bus_byte, bus_byte);
                    fail_count++;
                end
            end
        end
    end

    // writes past the last display column or the buffer are dropped
    task automatic store_char(input int r, input int c, input logic [BYTE_W-1:0] v);
        if (r < N_ROWS && c <= DISP_LAST_COL && c < N_COLS)
            shadow_buf[r][c] = v;
    endtask

    // a column outside a narrow buffer reads as zero
    function automatic logic [BYTE_W-1:0] read_char(input int r, input int c);
        if (r >= N_ROWS || c >= N_COLS)
            return '0;
        return shadow_buf[r][c];
    endfunction

    // one input transaction: random gap, hold until taken, then update the shadow
    task automatic send_item(input logic [FUNC_W-1:0] f, input logic [ROW_W-1:0] r,
                             input logic [COL_W-1:0] c, input logic [BYTE_W-1:0] ch,
                             input logic [NUM_W-1:0] num);
        bus_write_t w;
        int         scale;
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        func      <= f;
        row       <= r;
        col       <= c;
        char_code <= ch;
        number    <= num;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // taken at this edge
        case (f)
            FN_TICK:
            begin
                w.is_data = 1'b1;
                case (shadow_phase)
                    PH_SEL_ONE:
                    begin
                        w.is_data    = 1'b0;
                        w.bus_byte   = shadow_line_one;
                        shadow_phase = PH_WR_ONE;
                    end
                    PH_SEL_TWO:
                    begin
                        w.is_data    = 1'b0;
                        w.bus_byte   = shadow_line_two;
                        shadow_phase = PH_WR_TWO;
                    end
                    PH_WR_ONE:
                    begin
                        w.bus_byte = read_char(0, shadow_col);
                        if (shadow_col >= DISP_LAST_COL)
                        begin
                            shadow_col   = 0;
                            shadow_phase = PH_SEL_TWO;
                        end
                        else
                            shadow_col++;
                    end
                    default:
                    begin
                        w.bus_byte = read_char(shadow_scroll + 1, shadow_col);
                        if (shadow_col >= DISP_LAST_COL)
                        begin
                            shadow_col   = 0;
                            shadow_phase = PH_SEL_ONE;
                        end
                        else
                            shadow_col++;
                    end
                endcase
                bus_writes_due.push_back(w);
            end
            FN_CHAR:
                store_char(int'(r), int'(c), ch);
            FN_UP:
                if (shadow_scroll > 0 && shadow_scroll <= LAST_SCROLL)
                    shadow_scroll--;
                else
                    shadow_scroll = LAST_SCROLL;
            FN_DOWN:
                if (shadow_scroll < LAST_SCROLL)
                    shadow_scroll++;
                else
                    shadow_scroll = 0;
            FN_NUMBER:
            begin
                // thousands digit first, each digit checked against the edge on its own
                scale = 1000;
                for (int k = 0; k < DIGITS; k++)
                begin
                    store_char(int'(r), int'(c) + k,
                               BYTE_W'((int'(num) / scale) % DEC_BASE + ASCII_ZERO));
                    scale = scale / DEC_BASE;
                end
            end
            default:
                ;
        endcase
    endtask

    // one configuration transaction
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_LINE_ONE: shadow_line_one = value;
            CFG_LINE_TWO: shadow_line_two = value;
            default:      ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // stop sending, wait for every due bus write, then let the pipeline empty
    task automatic drain_results(input int extra);
        @(negedge clk);
        in_valid <= 1'b0;
        while (bus_writes_due.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // random mix: ticks most often, then writes, scroll moves and a few ignored codes
    task automatic run_traffic(input int count);
        logic [FUNC_W-1:0] f;
        logic [ROW_W-1:0]  r;
        logic [COL_W-1:0]  c;
        logic [BYTE_W-1:0] ch;
        logic [NUM_W-1:0]  num;
        int                pick;
        int                sent;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                f = FN_TICK;
            else if (pick < 65)
                f = FN_CHAR;
            else if (pick < 80)
                f = FN_NUMBER;
            else if (pick < 87)
                f = FN_UP;
            else if (pick < 94)
                f = FN_DOWN;
            else
                case ($urandom_range(0, 2))
                    0:       f = FN_UNUSED_A;
                    1:       f = FN_UNUSED_B;
                    default: f = FN_UNUSED_C;
                endcase
            r  = ROW_W'($urandom);
            // lean on the right-hand columns so numbers often run off the edge
            c  = ($urandom_range(0, 3) == 0) ? COL_W'($urandom_range(12, 15))
                                             : COL_W'($urandom_range(0, 15));
            ch = BYTE_W'($urandom);
            case ($urandom_range(0, 9))
                0:       num = '0;
                1:       num = '1;
                2:       num = 16'd9999;
                3:       num = 16'd10000;
                default: num = NUM_W'($urandom);
            endcase
            send_item(f, r, c, ch, num);
            if (f != FN_UNUSED_A && f != FN_UNUSED_B && f != FN_UNUSED_C)
                sent++;
        end
    endtask

    // field extremes, digits past the last column, ignored codes and scroll wrap
    task automatic test_buffer_edges();
        send_item(FN_TICK, '0, '0, '0, '0);
        send_item(FN_CHAR, 3'd0, 4'd0, 8'hFF, '0);
        send_item(FN_CHAR, 3'd0, 4'd15, 8'h00, '0);
        send_item(FN_TICK, '0, '0, '0, '0);
        send_item(FN_NUMBER, 3'd0, 4'd2, '0, 16'hFFFF);
        send_item(FN_NUMBER, 3'd0, 4'd12, '0, 16'h0000);
        // last digit falls off the line
        send_item(FN_NUMBER, 3'd1, 4'd13, '0, 16'd12345);
        // only the thousands digit lands
        send_item(FN_NUMBER, 3'd1, 4'd15, '1, 16'd9999);
        send_item(FN_NUMBER, 3'd7, 4'd4, '0, 16'd9);
        send_item(FN_CHAR, 3'd7, 4'd15, 8'hFF, '1);
        send_item(FN_CHAR, 3'd7, 4'd14, 8'h00, '1);
        send_item(FN_UNUSED_A, '1, '1, '1, '1);
        send_item(FN_UNUSED_B, '1, '1, '1, '1);
        send_item(FN_UNUSED_C, '0, '0, '0, '0);
        // up from the top wraps to the last scroll row, down from there wraps back
        send_item(FN_UP, '0, '0, '0, '0);
        send_item(FN_DOWN, '0, '0, '0, '0);
        send_item(FN_DOWN, '0, '0, '0, '0);
        send_item(FN_UP, '0, '0, '0, '0);
        repeat (3) send_item(FN_TICK, '0, '0, '0, '0);
    endtask

    // reset line commands under random traffic
    task automatic test_default_commands();
        run_traffic(180);
    endtask

    // lowest and highest command bytes, writes to unused indexes must be ignored
    task automatic test_command_extremes();
        drain_results(DRAIN_WAIT);
        write_reg(CFG_LINE_ONE, 8'h00);
        write_reg(CFG_LINE_TWO, 8'hFF);
        write_reg(CFG_SPARE_A, 8'h5A);
        write_reg(CFG_SPARE_B, 8'hA5);
        run_traffic(150);
    endtask

    // back to back transactions on both sides, no idling or stalls
    task automatic test_steady_stream();
        calm = 1'b1;
        run_traffic(150);
        calm = 1'b0;
    endtask

    // swapped extremes, with the sender holding off until all bus writes are out
    task automatic test_sender_pause();
        drain_results(DRAIN_WAIT);
        write_reg(CFG_LINE_ONE, 8'hFF);
        write_reg(CFG_LINE_TWO, 8'h00);
        run_traffic(80);
        drain_results(0);
        run_traffic(80);
    endtask

    // arbitrary command bytes
    task automatic test_random_commands();
        drain_results(DRAIN_WAIT);
        write_reg(CFG_LINE_ONE, BYTE_W'($urandom));
        write_reg(CFG_LINE_TWO, BYTE_W'($urandom));
        run_traffic(60);
    endtask

    initial
    begin
        // shadow matches the block after reset
        for (int r = 0; r < N_ROWS; r++)
            for (int c = 0; c < N_COLS; c++)
                shadow_buf[r][c] = '0;
        shadow_phase    = PH_SEL_ONE;
        shadow_col      = 0;
        shadow_scroll   = 0;
        shadow_line_one = LINE_ONE_RESET;
        shadow_line_two = LINE_TWO_RESET;

        while (!rst_n)
            @(posedge clk);

        test_buffer_edges();
        test_default_commands();
        test_command_extremes();
        test_steady_stream();
        test_sender_pause();
        test_random_commands();

        drain_results(DRAIN_WAIT);
        if (fail_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
